>>> hw/rtl/nals_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nals_pkg
// Shared constants for the nearest atlas label search block: field widths,
// command and status codes, configuration register indexes, reset values.
// ----------------------------------------------------------------------------
package nals_pkg;

    localparam int POS_W     = 5;
    localparam int VAL_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam int X_SIZE_DEF          = 32;
    localparam int Y_SIZE_DEF          = 32;
    localparam int Z_SIZE_DEF          = 32;
    localparam int MAX_HALF_WINDOW_DEF = 7;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_NOQUAL   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ASSIGNED = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_VAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_BG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z  = 3'd6;

    localparam logic [VAL_W-1:0] RADIUS_RST  = 16'd1280;
    localparam logic [VAL_W-1:0] SPACING_RST = 16'd256;

endpackage
`default_nettype wire

>>> hw/rtl/nals_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nals_if
// Valid/ready channels of the label search: command requests, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface nals_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic        [nals_pkg::POS_W-1:0]   pos_x;
    logic        [nals_pkg::POS_W-1:0]   pos_y;
    logic        [nals_pkg::POS_W-1:0]   pos_z;
    logic signed [nals_pkg::VAL_W-1:0]   data_value;
    logic        [nals_pkg::VAL_W-1:0]   atlas_label;

    modport source (output valid, command, pos_x, pos_y, pos_z, data_value, atlas_label,
                    input ready);
    modport sink   (input valid, command, pos_x, pos_y, pos_z, data_value, atlas_label,
                    output ready);
endinterface

interface nals_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nals_pkg::VAL_W-1:0]    assigned_label;
    logic [nals_pkg::STAT_W-1:0]   status;

    modport source (output valid, assigned_label, status, input ready);
    modport sink   (input valid, assigned_label, status, output ready);
endinterface

interface nals_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nals_pkg::CFG_IDX_W-1:0]   index;
    logic [nals_pkg::VAL_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/nearest_atlas_label_search_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_atlas_label_search_top
// Voxel store with a windowed nearest non-background atlas label search.
// ----------------------------------------------------------------------------
// A load request returns nothing. A query scans the clipped window one voxel
// per cycle, set by the single label memory read port, with two multiplier
// issues per window row. Before the scan, a shared restoring divider finds the
// half-window for each axis (an axis with zero spacing skips the divide), and
// after it the pipeline drains before the result is presented. The window is
// at most 15x15x15 voxels with the default half-window. Queries outside the
// volume or on a non-qualifying voxel finish without a window search. The
// request side is not ready while a query runs or its result waits to be taken.
// ----------------------------------------------------------------------------
module nearest_atlas_label_search_top #(
    parameter int X_SIZE          = nals_pkg::X_SIZE_DEF,
    parameter int Y_SIZE          = nals_pkg::Y_SIZE_DEF,
    parameter int Z_SIZE          = nals_pkg::Z_SIZE_DEF,
    parameter int MAX_HALF_WINDOW = nals_pkg::MAX_HALF_WINDOW_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    nals_cfg_if.sink         i_cfg,
    nals_req_if.sink         i_req,
    nals_rsp_if.source       o_rsp
);

    localparam int VAL_W  = nals_pkg::VAL_W;
    localparam int POS_W  = nals_pkg::POS_W;
    localparam int STAT_W = nals_pkg::STAT_W;
    localparam int CRD_W  = $clog2((2 ** POS_W) + MAX_HALF_WINDOW);
    localparam int VOXELS = X_SIZE * Y_SIZE * Z_SIZE;
    localparam int AW     = (VOXELS > 1) ? $clog2(VOXELS) : 1;
    localparam int PRD_W  = CRD_W + VAL_W;
    localparam int SQ_W   = 2 * PRD_W;
    localparam int YZ_W   = SQ_W + 1;
    localparam int D2_W   = SQ_W + 2;
    localparam int R2_W   = 2 * VAL_W;
    localparam int CNT_W  = $clog2(VAL_W);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_QUAL  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_R2    = 4'd4;
    localparam logic [3:0] S_ROWY  = 4'd5;
    localparam logic [3:0] S_ROWZ  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [1:0] TG_X  = 2'd0;
    localparam logic [1:0] TG_Y  = 2'd1;
    localparam logic [1:0] TG_Z  = 2'd2;
    localparam logic [1:0] TG_R2 = 2'd3;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    function automatic logic [AW-1:0] vox_addr(input logic [CRD_W-1:0] x,
                                               input logic [CRD_W-1:0] y,
                                               input logic [CRD_W-1:0] z);
        return AW'((int'(z) * Y_SIZE + int'(y)) * X_SIZE + int'(x));
    endfunction

    function automatic logic [CRD_W-1:0] adiff(input logic [CRD_W-1:0] a,
                                               input logic [CRD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // configuration
    logic             r_match_mode;
    logic [VAL_W-1:0] r_match_val, r_bg, r_radius, r_sp_x, r_sp_y, r_sp_z;

    // sequencer
    logic [3:0]       r_state, n_state;
    logic [CRD_W-1:0] r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic [CRD_W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [CRD_W-1:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi, r_z_lo, r_z_hi;
    logic [CRD_W-1:0] n_x_lo, n_x_hi, n_y_lo, n_y_hi, n_z_lo, n_z_hi;
    logic [1:0]       r_axis, n_axis;
    logic [VAL_W-1:0] r_rem, n_rem, r_quo, n_quo, r_dvd, n_dvd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_vld, n_out_vld;
    logic [VAL_W-1:0] r_out_lab, n_out_lab;
    logic [STAT_W-1:0] r_out_st, n_out_st;

    // multiplier pipeline and best-so-far
    logic             iss_vld;
    logic [1:0]       iss_tag;
    logic [CRD_W-1:0] iss_d;
    logic [VAL_W-1:0] iss_s;
    logic             r_s1_vld, r_s2_vld;
    logic [1:0]       r_s1_tag, r_s2_tag;
    logic [PRD_W-1:0] r_s1_prod;
    logic [SQ_W-1:0]  r_s2_sq;
    logic [VAL_W-1:0] r_s2_lab;
    logic [SQ_W-1:0]  r_sq_y;
    logic [YZ_W-1:0]  r_yz;
    logic [R2_W-1:0]  r_r2;
    logic [D2_W-1:0]  r_best;
    logic             r_found;
    logic [VAL_W-1:0] r_best_lab;
    logic [D2_W-1:0]  d2;
    logic             hit;

    // memories
    logic [VAL_W-1:0] r_data_mem  [VOXELS];
    logic [VAL_W-1:0] r_label_mem [VOXELS];
    logic [VAL_W-1:0] r_data_rd, r_lab_rd;
    logic [AW-1:0]    ld_addr, q_addr, lab_addr;
    logic             req_acc, in_vol, ld_we;

    // divider and window bound helpers
    logic [VAL_W-1:0] sel_sp;
    logic [CRD_W-1:0] sel_p;
    int               sel_max;
    logic [VAL_W:0]   rem_sh, rem_nx;
    logic             q_bit;
    logic [VAL_W-1:0] q_fin;
    logic [CRD_W-1:0] h_val, b_lo, b_hi, b_sum;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && (r_state == S_IDLE);
    assign in_vol      = (int'(i_req.pos_x) < X_SIZE) && (int'(i_req.pos_y) < Y_SIZE) &&
                         (int'(i_req.pos_z) < Z_SIZE);
    assign ld_we       = req_acc && (i_req.command == nals_pkg::CMD_LOAD) && in_vol;
    assign ld_addr     = vox_addr(CRD_W'(i_req.pos_x), CRD_W'(i_req.pos_y),
                                  CRD_W'(i_req.pos_z));
    assign q_addr      = vox_addr(r_px, r_py, r_pz);
    assign lab_addr    = vox_addr(r_x, r_y, r_z);

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.assigned_label = r_out_lab;
    assign o_rsp.status         = r_out_st;

    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            r_data_mem[ld_addr] <= $unsigned(i_req.data_value);
        end
        r_data_rd <= r_data_mem[q_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            r_label_mem[ld_addr] <= i_req.atlas_label;
        end
        r_lab_rd <= r_label_mem[lab_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_mode <= 1'b0;
            r_match_val  <= '0;
            r_bg         <= '0;
            r_radius     <= nals_pkg::RADIUS_RST;
            r_sp_x       <= nals_pkg::SPACING_RST;
            r_sp_y       <= nals_pkg::SPACING_RST;
            r_sp_z       <= nals_pkg::SPACING_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                nals_pkg::CFG_MATCH_MODE: r_match_mode <= i_cfg.data[0];
                nals_pkg::CFG_MATCH_VAL:  r_match_val  <= i_cfg.data;
                nals_pkg::CFG_ATLAS_BG:   r_bg         <= i_cfg.data;
                nals_pkg::CFG_RADIUS:     r_radius     <= i_cfg.data;
                nals_pkg::CFG_SPACING_X:  r_sp_x       <= i_cfg.data;
                nals_pkg::CFG_SPACING_Y:  r_sp_y       <= i_cfg.data;
                nals_pkg::CFG_SPACING_Z:  r_sp_z       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // per-axis divider operands
    always_comb begin
        unique case (r_axis)
            AX_X: begin
                sel_sp = r_sp_x; sel_p = r_px; sel_max = X_SIZE - 1;
            end
            AX_Y: begin
                sel_sp = r_sp_y; sel_p = r_py; sel_max = Y_SIZE - 1;
            end
            default: begin
                sel_sp = r_sp_z; sel_p = r_pz; sel_max = Z_SIZE - 1;
            end
        endcase
        rem_sh = {r_rem, r_dvd[VAL_W-1]};
        q_bit  = (rem_sh >= {1'b0, sel_sp});
        rem_nx = q_bit ? (rem_sh - {1'b0, sel_sp}) : rem_sh;
        q_fin  = {r_quo[VAL_W-2:0], q_bit};
        // floor(floor(2r/s)/2) equals floor(r/s)
        if (sel_sp == '0 || q_fin > VAL_W'(MAX_HALF_WINDOW)) begin
            h_val = CRD_W'(MAX_HALF_WINDOW);
        end else begin
            h_val = q_fin[CRD_W-1:0];
        end
        b_lo  = (sel_p > h_val) ? (sel_p - h_val) : '0;
        b_sum = sel_p + h_val;
        b_hi  = (int'(b_sum) > sel_max) ? CRD_W'(sel_max) : b_sum;
    end

    // distance check on the squared x term
    assign d2  = D2_W'(r_s2_sq) + D2_W'(r_yz);
    assign hit = r_s2_vld && (r_s2_tag == TG_X) && (r_s2_lab != r_bg) &&
                 (d2 <= D2_W'(r_r2)) && (!r_found || d2 < r_best);

    always_comb begin
        n_state   = r_state;
        n_px = r_px; n_py = r_py; n_pz = r_pz;
        n_x = r_x; n_y = r_y; n_z = r_z;
        n_x_lo = r_x_lo; n_x_hi = r_x_hi;
        n_y_lo = r_y_lo; n_y_hi = r_y_hi;
        n_z_lo = r_z_lo; n_z_hi = r_z_hi;
        n_axis    = r_axis;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dvd     = r_dvd;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld;
        n_out_lab = r_out_lab;
        n_out_st  = r_out_st;
        iss_vld   = 1'b0;
        iss_tag   = TG_X;
        iss_d     = adiff(r_x, r_px);
        iss_s     = r_sp_x;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_px = CRD_W'(i_req.pos_x);
                    n_py = CRD_W'(i_req.pos_y);
                    n_pz = CRD_W'(i_req.pos_z);
                    if (i_req.command == nals_pkg::CMD_QUERY) begin
                        if (in_vol) begin
                            n_state = S_READ;
                        end else begin
                            n_out_vld = 1'b1;
                            n_out_lab = '0;
                            n_out_st  = nals_pkg::ST_NOQUAL;
                            n_state   = S_OUT;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_QUAL;
            end
            S_QUAL: begin
                if ((r_match_mode != 1'b0) ? (r_data_rd == r_match_val)
                                           : (r_data_rd != r_match_val)) begin
                    n_axis  = AX_X;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_dvd   = r_radius;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_out_vld = 1'b1;
                    n_out_lab = '0;
                    n_out_st  = nals_pkg::ST_NOQUAL;
                    n_state   = S_OUT;
                end
            end
            S_DIV: begin
                n_rem = rem_nx[VAL_W-1:0];
                n_quo = q_fin;
                n_dvd = {r_dvd[VAL_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                // zero spacing skips the divide
                if (sel_sp == '0 || r_cnt == CNT_W'(VAL_W - 1)) begin
                    unique case (r_axis)
                        AX_X:    begin n_x_lo = b_lo; n_x_hi = b_hi; end
                        AX_Y:    begin n_y_lo = b_lo; n_y_hi = b_hi; end
                        default: begin n_z_lo = b_lo; n_z_hi = b_hi; end
                    endcase
                    n_rem = '0;
                    n_quo = '0;
                    n_dvd = r_radius;
                    n_cnt = '0;
                    if (r_axis == AX_Z) begin
                        n_state = S_R2;
                    end else begin
                        n_axis = r_axis + 1'b1;
                    end
                end
            end
            S_R2: begin
                iss_vld = 1'b1;
                iss_tag = TG_R2;
                iss_d   = CRD_W'(1);
                iss_s   = r_radius;
                n_x     = r_x_lo;
                n_y     = r_y_lo;
                n_z     = r_z_lo;
                n_state = S_ROWY;
            end
            S_ROWY: begin
                iss_vld = 1'b1;
                iss_tag = TG_Y;
                iss_d   = adiff(r_y, r_py);
                iss_s   = r_sp_y;
                n_state = S_ROWZ;
            end
            S_ROWZ: begin
                iss_vld = 1'b1;
                iss_tag = TG_Z;
                iss_d   = adiff(r_z, r_pz);
                iss_s   = r_sp_z;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                iss_vld = 1'b1;
                if (r_x != r_x_hi) begin
                    n_x = r_x + 1'b1;
                end else begin
                    n_x = r_x_lo;
                    if (r_y != r_y_hi) begin
                        n_y     = r_y + 1'b1;
                        n_state = S_ROWY;
                    end else if (r_z != r_z_hi) begin
                        n_y     = r_y_lo;
                        n_z     = r_z + 1'b1;
                        n_state = S_ROWY;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    n_out_vld = 1'b1;
                    n_out_lab = r_found ? r_best_lab : '0;
                    n_out_st  = r_found ? nals_pkg::ST_ASSIGNED : nals_pkg::ST_NONE;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_out_vld = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_axis    <= AX_X;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_s1_vld  <= iss_vld;
            r_s2_vld  <= r_s1_vld;
            r_axis    <= n_axis;
            r_cnt     <= n_cnt;
            if (r_state == S_R2) begin
                r_found <= 1'b0;
            end else if (hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px; r_py <= n_py; r_pz <= n_pz;
        r_x  <= n_x;  r_y  <= n_y;  r_z  <= n_z;
        r_x_lo <= n_x_lo; r_x_hi <= n_x_hi;
        r_y_lo <= n_y_lo; r_y_hi <= n_y_hi;
        r_z_lo <= n_z_lo; r_z_hi <= n_z_hi;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvd     <= n_dvd;
        r_out_lab <= n_out_lab;
        r_out_st  <= n_out_st;

        // shared two-stage multiplier: (d*s) then its square
        r_s1_tag  <= iss_tag;
        r_s1_prod <= PRD_W'(iss_d) * PRD_W'(iss_s);
        r_s2_tag  <= r_s1_tag;
        r_s2_sq   <= SQ_W'(r_s1_prod) * SQ_W'(r_s1_prod);
        r_s2_lab  <= r_lab_rd;

        if (r_s2_vld) begin
            unique case (r_s2_tag)
                TG_R2:   r_r2   <= r_s2_sq[R2_W-1:0];
                TG_Y:    r_sq_y <= r_s2_sq;
                TG_Z:    r_yz   <= YZ_W'(r_sq_y) + YZ_W'(r_s2_sq);
                default: ;
            endcase
        end
        if (hit) begin
            r_best     <= d2;
            r_best_lab <= r_s2_lab;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/nals_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nals_props
// Port-level checks for the nearest atlas label search block.
// ----------------------------------------------------------------------------
module nals_props (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_req_command,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [nals_pkg::VAL_W-1:0]    i_rsp_label,
    input wire logic [nals_pkg::STAT_W-1:0]   i_rsp_status
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == nals_pkg::ST_NOQUAL ||
                         i_rsp_status == nals_pkg::ST_ASSIGNED ||
                         i_rsp_status == nals_pkg::ST_NONE))
        else $error("result status out of range");

    a_label_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != nals_pkg::ST_ASSIGNED) |-> (i_rsp_label == '0))
        else $error("label not zero on unassigned result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_req_command == nals_pkg::CMD_QUERY)
        |=> !i_req_ready)
        else $error("request taken while query in flight");

    a_rsp_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request side ready with result pending");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_label) && $stable(i_rsp_status)))
        else $error("stalled result changed");

endmodule

bind nearest_atlas_label_search_top nals_props u_nals_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_command (i_req.command),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_label   (o_rsp.assigned_label),
    .i_rsp_status  (o_rsp.status)
);
`default_nettype wire
